>>> rtl/core/bilbs_pkg.sv
// Package for the block index lower-bound search.
// Field widths, item mode codes, the query token and state machine encodings.
package bilbs_pkg;

  localparam int KEY_W = 64;
  localparam int POS_W = 13;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // query token handed down the chain, one level per hop
  typedef struct packed {
    logic vld;   // token present this cycle
    logic seen;  // a non-empty level above already narrowed the block
  } qtok_t;

  typedef enum logic [1:0] {
    C_IDLE = 2'b01,
    C_SCAN = 2'b10
  } cell_st_e;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_APP  = 4'b0010,
    T_QRY  = 4'b0100,
    T_HOLD = 4'b1000
  } top_st_e;

endpackage

>>> rtl/core/bilbs_cell.sv
// One level of the index: its key memory, fill length and block scanner.
// Depends on bilbs_pkg. Appends travel up the chain, queries travel down.
module bilbs_cell #(
  parameter int CAP   = 8,
  parameter int ORDER = 8,
  parameter int CNT_W = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       app_vld_i,
  input  logic [bilbs_pkg::KEY_W-1:0] app_key_i,
  output logic                       up_vld_o,
  output logic [bilbs_pkg::KEY_W-1:0] up_key_o,
  input  logic [bilbs_pkg::KEY_W-1:0] cmp_key_i,
  input  bilbs_pkg::qtok_t           q_i,
  input  logic [CNT_W-1:0]           start_i,
  output bilbs_pkg::qtok_t           q_o,
  output logic [CNT_W-1:0]           pos_o
);
  import bilbs_pkg::*;

  localparam int MEMD  = (CAP > 0) ? CAP : 1;
  localparam int IDX_W = (MEMD > 1) ? $clog2(MEMD) : 1;
  localparam int PH_W  = $clog2(ORDER);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);
  localparam logic [PH_W-1:0]  PH_LAST = PH_W'(ORDER - 1);

  logic [KEY_W-1:0] mem [MEMD];
  logic [KEY_W-1:0] rdata_q;
  logic [KEY_W-1:0] up_key_q;
  logic [CNT_W-1:0] len_q, ptr_q, end_q, pos_q;
  logic [PH_W-1:0]  ph_q;
  logic             up_vld_q, rd_vld_q;
  qtok_t            qo_q;
  cell_st_e         st_q;

  logic             we;
  logic [CNT_W-1:0] s_clamp, s_blk, e_blk;
  logic [CNT_W:0]   s_sum;

  assign we = app_vld_i && (len_q < CAP_C);

  // block bounds: whole level at the top, else ORDER entries from start
  always_comb begin
    s_clamp = (start_i > len_q) ? len_q : start_i;
    s_sum   = {1'b0, s_clamp} + (CNT_W+1)'(ORDER);
    s_blk   = q_i.seen ? s_clamp : '0;
    e_blk   = len_q;
    if (q_i.seen && (s_sum <= {1'b0, len_q})) begin
      e_blk = s_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[len_q[IDX_W-1:0]] <= app_key_i;
    end
    rdata_q  <= mem[ptr_q[IDX_W-1:0]];
    up_key_q <= app_key_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ph_q     <= '0;
      up_vld_q <= 1'b0;
      rd_vld_q <= 1'b0;
      qo_q     <= '0;
      st_q     <= C_IDLE;
      ptr_q    <= '0;
      end_q    <= '0;
      pos_q    <= '0;
    end else begin
      up_vld_q <= we && (len_q != '0) && (ph_q == '0);
      if (clear_i) begin
        len_q <= '0;
        ph_q  <= '0;
      end else if (we) begin
        len_q <= len_q + 1'b1;
        ph_q  <= (ph_q == PH_LAST) ? '0 : ph_q + 1'b1;
      end
      unique case (st_q)
        C_IDLE: begin
          rd_vld_q <= 1'b0;
          if (q_i.vld && !q_i.seen && (len_q == '0)) begin
            // empty level above the top: pass through untouched
            qo_q  <= '{vld: 1'b1, seen: 1'b0};
            pos_q <= '0;
          end else begin
            qo_q <= '0;
            if (q_i.vld) begin
              ptr_q <= s_blk;
              end_q <= e_blk;
              pos_q <= s_blk;
              st_q  <= C_SCAN;
            end
          end
        end
        C_SCAN: begin
          rd_vld_q <= (ptr_q < end_q);
          if (ptr_q < end_q) begin
            ptr_q <= ptr_q + 1'b1;
          end
          if (rd_vld_q && (rdata_q < cmp_key_i)) begin
            pos_q <= pos_q + 1'b1;
          end
          if ((ptr_q == end_q) && !rd_vld_q) begin
            qo_q <= '{vld: 1'b1, seen: 1'b1};
            st_q <= C_IDLE;
          end else begin
            qo_q <= '0;
          end
        end
        default: begin
          qo_q <= '0;
          st_q <= C_IDLE;
        end
      endcase
    end
  end

  assign up_vld_o = up_vld_q;
  assign up_key_o = up_key_q;
  assign q_o      = qo_q;
  assign pos_o    = pos_q;

endmodule

>>> rtl/core/block_index_lower_bound_search.sv
// Lower-bound search over sorted 64-bit keys, index levels built on load.
// Append: the key is accepted, then the block stays busy while the separator
// hands up the cell chain. Clear empties all levels. Query: an empty level
// above the top is passed through; a searched level scans ORDER entries below
// the top and the whole top level; the result then goes to the output register.
// One item in flight. Reset empties all levels.
module block_index_lower_bound_search #(
  parameter int ORDER      = 8,
  parameter int MAX_KEYS   = 4096,
  parameter int MAX_LEVELS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bilbs_pkg::MODE_W-1:0] mode_i,
  input  logic [bilbs_pkg::KEY_W-1:0]  search_key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bilbs_pkg::POS_W-1:0]  position_o
);
  import bilbs_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int NCELL = MAX_LEVELS + 1;
  localparam int WT_W  = $clog2(NCELL + 1);

  // capacity per separator level, capped so the packed store fits MAX_KEYS
  localparam int C0 = (MAX_KEYS - 1) / ORDER;
  localparam int C1 = (C0 > 0) ? (C0 - 1) / ORDER : 0;
  localparam int C2 = (C1 > 0) ? (C1 - 1) / ORDER : 0;
  localparam int C3 = (C2 > 0) ? (C2 - 1) / ORDER : 0;
  localparam int C4 = (C3 > 0) ? (C3 - 1) / ORDER : 0;
  localparam int C5 = (C4 > 0) ? (C4 - 1) / ORDER : 0;
  localparam int C6 = (C5 > 0) ? (C5 - 1) / ORDER : 0;
  localparam int C7 = (C6 > 0) ? (C6 - 1) / ORDER : 0;
  localparam int B1 = C0;
  localparam int B2 = B1 + C1;
  localparam int B3 = B2 + C2;
  localparam int B4 = B3 + C3;
  localparam int B5 = B4 + C4;
  localparam int B6 = B5 + C5;
  localparam int B7 = B6 + C6;
  localparam int R1 = (MAX_KEYS > B1) ? MAX_KEYS - B1 : 0;
  localparam int R2 = (MAX_KEYS > B2) ? MAX_KEYS - B2 : 0;
  localparam int R3 = (MAX_KEYS > B3) ? MAX_KEYS - B3 : 0;
  localparam int R4 = (MAX_KEYS > B4) ? MAX_KEYS - B4 : 0;
  localparam int R5 = (MAX_KEYS > B5) ? MAX_KEYS - B5 : 0;
  localparam int R6 = (MAX_KEYS > B6) ? MAX_KEYS - B6 : 0;
  localparam int R7 = (MAX_KEYS > B7) ? MAX_KEYS - B7 : 0;
  // index 0 is the leaf level holding all keys
  localparam int CAPS [9] = '{MAX_KEYS, C0,
                              (C1 < R1) ? C1 : R1, (C2 < R2) ? C2 : R2,
                              (C3 < R3) ? C3 : R3, (C4 < R4) ? C4 : R4,
                              (C5 < R5) ? C5 : R5, (C6 < R6) ? C6 : R6,
                              (C7 < R7) ? C7 : R7};

  top_st_e          st_q;
  logic [WT_W-1:0]  wait_q;
  logic [KEY_W-1:0] key_q;
  logic [POS_W-1:0] res_q, out_q;
  logic             out_vld_q;
  logic             acc, app, qry, clr;
  logic             load_out;

  logic             up_vld [NCELL];
  logic [KEY_W-1:0] up_key [NCELL];
  qtok_t            qtok   [NCELL];
  logic [CNT_W-1:0] pos    [NCELL];
  qtok_t            q_top;

  assign in_ready_o = (st_q == T_IDLE);
  assign acc = in_valid_i && in_ready_o;
  assign app = acc && (mode_i == MODE_APPEND);
  assign qry = acc && (mode_i == MODE_QUERY);
  assign clr = acc && (mode_i == MODE_CLEAR);
  assign q_top = '{vld: qry, seen: 1'b0};

  // result moves to the output register once that register is free
  assign load_out = (st_q == T_HOLD) && (!out_vld_q || out_ready_i);

  // chain: appends enter the leaf and climb, queries enter the top and descend
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic             a_vld;
    logic [KEY_W-1:0] a_key;
    qtok_t            q_in;
    logic [CNT_W-1:0] s_in;
    if (g == 0) begin : g_leaf
      assign a_vld = app;
      assign a_key = search_key_i;
    end else begin : g_lvl
      assign a_vld = up_vld[g-1];
      assign a_key = up_key[g-1];
    end
    if (g == NCELL - 1) begin : g_top
      assign q_in = q_top;
      assign s_in = '0;
    end else begin : g_mid
      // child block starts at the parent position times ORDER
      assign q_in = qtok[g+1];
      assign s_in = CNT_W'(pos[g+1] * ORDER);
    end
    bilbs_cell #(
      .CAP  (CAPS[g]),
      .ORDER(ORDER),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (clr),
      .app_vld_i(a_vld),
      .app_key_i(a_key),
      .up_vld_o (up_vld[g]),
      .up_key_o (up_key[g]),
      .cmp_key_i(key_q),
      .q_i      (q_in),
      .start_i  (s_in),
      .q_o      (qtok[g]),
      .pos_o    (pos[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      key_q <= search_key_i;
    end
    if (qtok[0].vld) begin
      res_q <= POS_W'(pos[0]);
    end
  end

  // sequencer plus output register; result waits in res_q if the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= T_IDLE;
      wait_q    <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (st_q)
        T_IDLE: begin
          if (app) begin
            wait_q <= WT_W'(NCELL);
            st_q   <= T_APP;
          end else if (qry) begin
            st_q <= T_QRY;
          end
        end
        T_APP: begin
          wait_q <= wait_q - 1'b1;
          if (wait_q == '0) begin
            st_q <= T_IDLE;
          end
        end
        T_QRY: begin
          if (qtok[0].vld) begin
            st_q <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (load_out) begin
            out_q <= res_q;
            st_q  <= T_IDLE;
          end
        end
        default: st_q <= T_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign position_o  = out_q;

endmodule

>>> tb/block_index_lower_bound_search_test.sv
`timescale 1ns / 1ps
// Testbench for block_index_lower_bound_search: directed table, then random
// load/query sequences checked against an in-bench predictor.
// Depends on bilbs_pkg and the block's RTL only.
module block_index_lower_bound_search_test;
  import bilbs_pkg::*;

  localparam int ORDER      = 8;
  localparam int MAX_KEYS   = 4096;
  localparam int MAX_LEVELS = 4;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;   // ignored by the block
  localparam logic [KEY_W-1:0]  KEY_MAX  = {KEY_W{1'b1}};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i = MODE_APPEND;
  logic [KEY_W-1:0]    search_key_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [POS_W-1:0]    position_o;

  block_index_lower_bound_search #(
    .ORDER(ORDER), .MAX_KEYS(MAX_KEYS), .MAX_LEVELS(MAX_LEVELS)
  ) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .mode_i(mode_i), .search_key_i(search_key_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .position_o(position_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Generous fixed limit; the slowest correct run is well under a tenth.
  initial begin
    #30_000_000;
    $display("block_index_lower_bound_search_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor: own copy of the key store and the separator levels.
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0] mirror_keys [MAX_KEYS];
  logic [KEY_W-1:0] mirror_seps [MAX_KEYS];
  int               mirror_count;
  int               lvl_len  [MAX_LEVELS];
  int               lvl_base [MAX_LEVELS];
  int               lvl_cap  [MAX_LEVELS];

  logic [POS_W-1:0] pending_positions [$];

  int  errors = 0;
  int  beats_in = 0;
  int  queries_seen = 0, appends_sent = 0, clears_sent = 0;
  bit  no_idle = 1'b0;      // burst stretch: both sides stop idling
  bit  hold_req = 1'b0;     // pressure request to the receiver

  function automatic void mirror_init();
    int cap, base;
    cap = (MAX_KEYS - 1) / ORDER;
    base = 0;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      lvl_base[l] = base;
      lvl_cap[l]  = cap;
      base += cap;
      cap = (cap > 0) ? (cap - 1) / ORDER : 0;
      lvl_len[l] = 0;
    end
    mirror_count = 0;
  endfunction

  function automatic void mirror_clear();
    mirror_count = 0;
    for (int l = 0; l < MAX_LEVELS; l++) lvl_len[l] = 0;
  endfunction

  // Store full drops the key; a separator with no room above is not kept.
  function automatic void mirror_append(logic [KEY_W-1:0] k);
    int idx, j;
    bit stop;
    if (mirror_count >= MAX_KEYS) return;
    mirror_keys[mirror_count] = k;
    idx = mirror_count;
    mirror_count++;
    stop = 1'b0;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      if (!stop) begin
        if (idx == 0 || idx % ORDER != 0) stop = 1'b1;
        else begin
          j = idx / ORDER - 1;
          if (j >= lvl_cap[l] || lvl_base[l] + j >= MAX_KEYS) stop = 1'b1;
          else begin
            mirror_seps[lvl_base[l] + j] = k;
            lvl_len[l] = j + 1;
            idx = j;
          end
        end
      end
    end
  endfunction

  // Descent: top present level searched whole, ORDER entries below it.
  function automatic logic [POS_W-1:0] lower_bound_pos(logic [KEY_W-1:0] k);
    int top, start, stop_at, len, pos;
    top = -1;
    for (int l = MAX_LEVELS - 1; l >= 0; l--)
      if (top < 0 && lvl_len[l] > 0) top = l;
    start = 0;
    for (int l = top; l >= 0; l--) begin
      len = lvl_len[l];
      if (start > len) start = len;
      stop_at = (l == top) ? len : start + ORDER;
      if (stop_at > len) stop_at = len;
      pos = start;
      for (int i = start; i < stop_at; i++)
        if (lvl_base[l] + i < MAX_KEYS && mirror_seps[lvl_base[l] + i] < k) pos++;
      start = pos * ORDER;
    end
    if (start > mirror_count) start = mirror_count;
    stop_at = (top < 0) ? mirror_count : start + ORDER;
    if (stop_at > mirror_count) stop_at = mirror_count;
    pos = start;
    for (int i = start; i < stop_at; i++)
      if (mirror_keys[i] < k) pos++;
    return pos[POS_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one beat per call; valid stays high across back-to-back beats.
  // ---------------------------------------------------------------------
  task automatic send_beat(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                           bit typed, logic [POS_W-1:0] typed_pos);
    int gap;
    logic [POS_W-1:0] exp_pos;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    search_key_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    beats_in++;
    case (m)
      MODE_APPEND: begin
        mirror_append(k);
        appends_sent++;
      end
      MODE_QUERY: begin
        exp_pos = typed ? typed_pos : lower_bound_pos(k);
        pending_positions = {pending_positions, exp_pos};
        queries_seen++;
      end
      MODE_CLEAR: begin
        mirror_clear();
        clears_sent++;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Receiver: per-beat stall, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin
    int rx_wait, hold_left;
    logic [POS_W-1:0] want;
    rx_wait = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_positions.size() == 0) begin
          $display("%0t: unexpected result beat, position %0d", $time, position_o);
          errors++;
        end else begin
          want = pending_positions.pop_front();
          if (position_o !== want) begin
            $display("%0t: position mismatch, expected %0d actual %0d",
                     $time, want, position_o);
            errors++;
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 17);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Pressure: stall results for a long stretch while queries keep coming.
  initial begin
    wait (queries_seen >= 20);
    hold_req = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------
  typedef struct {
    logic [MODE_W-1:0] m;
    logic [KEY_W-1:0]  k;
    bit                typed;
    logic [POS_W-1:0]  pos;
  } dir_row_t;

  dir_row_t dir_rows [18] = '{
    '{MODE_QUERY,  '0,      1, 13'd0},   // empty store after reset
    '{MODE_QUERY,  KEY_MAX, 1, 13'd0},
    '{MODE_NOP,    KEY_MAX, 0, 13'd0},   // ignored
    '{MODE_APPEND, '0,      0, 13'd0},
    '{MODE_APPEND, KEY_MAX, 0, 13'd0},
    '{MODE_QUERY,  '0,      1, 13'd0},
    '{MODE_QUERY,  64'd1,   1, 13'd1},
    '{MODE_QUERY,  KEY_MAX, 1, 13'd1},
    '{MODE_CLEAR,  KEY_MAX, 0, 13'd0},
    '{MODE_QUERY,  KEY_MAX, 1, 13'd0},   // empty after clear
    '{MODE_APPEND, 64'd50,  0, 13'd0},   // not ascending from here
    '{MODE_APPEND, 64'd30,  0, 13'd0},
    '{MODE_APPEND, 64'd40,  0, 13'd0},
    '{MODE_QUERY,  64'd35,  0, 13'd0},
    '{MODE_QUERY,  64'd45,  0, 13'd0},
    '{MODE_QUERY,  64'h8000_0000_0000_0000, 0, 13'd0},
    '{MODE_NOP,    '0,      0, 13'd0},
    '{MODE_CLEAR,  '0,      0, 13'd0}
  };

  // One load sequence: clear, n keys with stray ignored modes, then queries mostly around stored keys.
  task automatic run_sequence(int n, bit sorted, int nq);
    logic [KEY_W-1:0] k, base;
    int idx;
    base = {$urandom, $urandom};
    if (sorted && base > KEY_MAX - 64'd100_000) base = base - 64'd100_000;
    send_beat(MODE_CLEAR, {$urandom, $urandom}, 0, '0);
    k = base;
    for (int i = 0; i < n; i++) begin
      if (sorted) k = k + $urandom_range(0, 5);
      else k = {$urandom, $urandom};
      if ($urandom_range(0, 40) == 0) send_beat(MODE_NOP, {$urandom, $urandom}, 0, '0);
      send_beat(MODE_APPEND, k, 0, '0);
    end
    for (int q = 0; q < nq; q++) begin
      case ($urandom_range(0, 5))
        0: k = {$urandom, $urandom};
        1: k = ($urandom_range(0, 1) != 0) ? '0 : KEY_MAX;
        default: begin
          if (mirror_count == 0) k = base;
          else begin
            idx = $urandom_range(0, mirror_count - 1);
            k = mirror_keys[idx] + 64'($signed($urandom_range(0, 2)) - 1);
          end
        end
      endcase
      send_beat(MODE_QUERY, k, 0, '0);
    end
  endtask

  initial begin
    int n, nq;
    mirror_init();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].m, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].pos);

    // Deep sorted load so the upper separator levels fill, then queries.
    run_sequence(700, 1, 40);

    while (beats_in < 1900) begin
      if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 700)
                                      : $urandom_range(0, 80);
      nq = $urandom_range(5, 15);
      run_sequence(n, $urandom_range(0, 9) != 0, nq);
    end
    in_valid_i <= 1'b0;

    wait (pending_positions.size() == 0);
    repeat (60) @(posedge clk_i);

    $display("Ran %0d appends, %0d clears, %0d checked queries; deep loads,",
             appends_sent, clears_sent, queries_seen);
    $display("unsorted keys, ignored modes and a long result stall included.");
    if (errors == 0) begin
      $display("block_index_lower_bound_search_test OK");
    end else begin
      $display("block_index_lower_bound_search_test NOT OK");
    end
    $finish;
  end

endmodule
